@@ rtl/dtc_pkg.sv @@
// Shared types, constants and helper functions for the domino tiling counter.
// No dependencies; every other file in the block imports this package.
`timescale 1ns / 1ps
package dtc_pkg;

  localparam int DATA_W  = 30;
  localparam int COUNT_W = 31;
  localparam int ROWS_W  = 3;
  localparam int RUN_W   = 7;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 3'd2;
  localparam logic [DATA_W-1:0] MODULUS    = 30'd1000000007;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

  function automatic logic even_runs(input logic [RUN_W-1:0] x);
    logic odd;
    logic bad;
    odd = 1'b0;
    bad = 1'b0;
    for (int b = 0; b < RUN_W; b++) begin
      if (x[b]) begin
        odd = !odd;
      end else if (odd) begin
        bad = 1'b1;
      end
    end
    return !bad && !odd;
  endfunction

  function automatic word_t add_mod(input word_t a, input word_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/dtc_mul_cell.sv @@
// One cell of the modular multiplier chain: consumes one multiplier bit.
// Depends on dtc_pkg for the word type, the modulus and the beat tag.
`timescale 1ns / 1ps
module dtc_mul_cell
  import dtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  word_t    a_in,
  input  word_t    b_in,
  input  word_t    acc_in,
  input  mac_tag_t tag_in,
  output word_t    a_out,
  output word_t    b_out,
  output word_t    acc_out,
  output mac_tag_t tag_out
);

  localparam logic [DATA_W+1:0] MOD_W  = {2'b00, MODULUS};
  localparam logic [DATA_W+1:0] MOD2_W = {1'b0, MODULUS, 1'b0};

  logic [DATA_W+1:0] step;
  word_t             acc_next;

  always_comb begin
    step = {1'b0, acc_in, 1'b0} + (b_in[DATA_W-1] ? {2'b00, a_in} : '0);
    if (step >= MOD2_W) begin
      step = step - MOD2_W;
    end else if (step >= MOD_W) begin
      step = step - MOD_W;
    end
    acc_next = step[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    a_out   <= a_in;
    b_out   <= {b_in[DATA_W-2:0], 1'b0};
    acc_out <= acc_next;
  end

endmodule

@@ rtl/dtc_mod_mul.sv @@
// Pipelined modular multiplier built as a chain of bit cells, MSB first.
// Depends on dtc_pkg and dtc_mul_cell.
`timescale 1ns / 1ps
module dtc_mod_mul
  import dtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  word_t    a,
  input  word_t    b,
  input  mac_tag_t tag_in,
  output word_t    prod,
  output mac_tag_t tag_out
);

  word_t    a_s   [DATA_W+1];
  word_t    b_s   [DATA_W+1];
  word_t    acc_s [DATA_W+1];
  mac_tag_t tag_s [DATA_W+1];

  assign a_s[0]   = a;
  assign b_s[0]   = b;
  assign acc_s[0] = '0;
  assign tag_s[0] = tag_in;

  for (genvar g = 0; g < DATA_W; g++) begin : g_cell
    dtc_mul_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .a_in    (a_s[g]),
      .b_in    (b_s[g]),
      .acc_in  (acc_s[g]),
      .tag_in  (tag_s[g]),
      .a_out   (a_s[g+1]),
      .b_out   (b_s[g+1]),
      .acc_out (acc_s[g+1]),
      .tag_out (tag_s[g+1])
    );
  end

  assign prod    = acc_s[DATA_W];
  assign tag_out = tag_s[DATA_W];

endmodule

@@ rtl/domino_tiling_counter_unit.sv @@
// Top level of the domino tiling counter: sequencer, matrix memories, accumulator.
// Depends on dtc_pkg and dtc_mod_mul.
//
// Usage: the rows register is written through cfg_write/cfg_data; the user
// must do so only while idle; the block itself does not enforce it.
// It resets to 2. Each input beat on in_valid/in_ready carries column_count
// and yields one output beat on out_valid/out_ready carrying tiling_count.
// With D = min(2^rows, MATRIX_DIM) a query first builds the D x D transfer
// matrix, then runs one matrix product per exponent step: one product term
// per cycle through the 30-cell multiplier chain, then a copy sweep of the
// scratch memory. There are up to about 2*log2(column_count) products,
// followed by a final sum. One query is worked on at a time; in_ready is
// high only when idle. The result sits in an output register, so a stalled
// receiver does not block the next query from being accepted. Reset clears
// the control state and sets rows to 2; the memories need no clearing.
`timescale 1ns / 1ps
module domino_tiling_counter_unit
  import dtc_pkg::*;
#(
  parameter int MATRIX_DIM = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [ROWS_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COUNT_W-1:0] column_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  tiling_count
);

  localparam int IDX_W  = $clog2(MATRIX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = MATRIX_DIM * MATRIX_DIM;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_BUILD    = 4'd1;
  localparam logic [3:0] ST_PICK     = 4'd2;
  localparam logic [3:0] ST_MUL      = 4'd3;
  localparam logic [3:0] ST_DRAIN    = 4'd4;
  localparam logic [3:0] ST_COPY     = 4'd5;
  localparam logic [3:0] ST_COPY_END = 4'd6;
  localparam logic [3:0] ST_SUM      = 4'd7;
  localparam logic [3:0] ST_SUM_END  = 4'd8;
  localparam logic [3:0] ST_FINISH   = 4'd9;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MATRIX_DIM) + ADDR_W'(c);
  endfunction

  word_t t_mem [DEPTH];
  word_t p_mem [DEPTH];
  word_t s_mem [DEPTH];

  logic [3:0]         state;
  logic [ROWS_W-1:0]  rows;
  logic [IDX_W-1:0]   dim_m1;
  logic [COUNT_W-1:0] expo;
  logic               mul_to_p;
  logic [IDX_W-1:0]   ci, cj, ck;
  logic [IDX_W-1:0]   wi, wj;
  logic               wr_done;
  logic [IDX_W:0]     ntiles;
  word_t              total;
  word_t              acc;
  mac_tag_t           iss_tag;
  logic               cp_valid;
  logic [ADDR_W-1:0]  cp_addr;
  logic               sm_valid;

  word_t t_qa, t_qb, p_q, s_q;
  word_t mul_a;
  word_t prod;
  mac_tag_t mul_tag;
  word_t acc_sum;

  logic ci_last, cj_last, ck_last;
  logic hit;
  logic [IDX_W:0] bsum;
  logic [8:0] dim_raw;
  logic [8:0] dim_sat;

  logic [ADDR_W-1:0] t_ra, t_rb, p_ra, s_ra, ij_addr;
  logic              t_we, p_we, s_we;
  logic [ADDR_W-1:0] t_wa, p_wa, s_wa;
  word_t             t_wd, p_wd;

  assign in_ready = (state == ST_IDLE);

  assign ci_last = (ci == dim_m1);
  assign cj_last = (cj == dim_m1);
  assign ck_last = (ck == dim_m1);

  assign hit = ((ci & ck) == '0) && ((cj & ck) == ck) && even_runs(RUN_W'(cj ^ ck));
  assign bsum = ntiles + (IDX_W + 1)'(hit);

  assign dim_raw = 9'd1 << rows;
  assign dim_sat = (dim_raw > 9'(MATRIX_DIM)) ? 9'(MATRIX_DIM) : dim_raw;

  assign ij_addr = mk_addr(ci, cj);
  assign t_ra    = mk_addr(ci, ck);
  assign t_rb    = mk_addr(ck, cj);
  assign p_ra    = (state == ST_SUM) ? ij_addr : t_ra;
  assign s_ra    = ij_addr;

  always_comb begin
    t_we = 1'b0;
    p_we = 1'b0;
    t_wa = ij_addr;
    p_wa = ij_addr;
    t_wd = DATA_W'(bsum);
    p_wd = (ci == cj) ? DATA_W'(1) : '0;
    if (state == ST_BUILD && ck_last) begin
      t_we = 1'b1;
      p_we = 1'b1;
    end else if (cp_valid) begin
      t_we = !mul_to_p;
      p_we = mul_to_p;
      t_wa = cp_addr;
      p_wa = cp_addr;
      t_wd = s_q;
      p_wd = s_q;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      t_mem[t_wa] <= t_wd;
    end
    if (p_we) begin
      p_mem[p_wa] <= p_wd;
    end
    if (s_we) begin
      s_mem[s_wa] <= acc_sum;
    end
    t_qa <= t_mem[t_ra];
    t_qb <= t_mem[t_rb];
    p_q  <= p_mem[p_ra];
    s_q  <= s_mem[s_ra];
  end

  assign mul_a = mul_to_p ? p_q : t_qa;

  dtc_mod_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (mul_a),
    .b       (t_qb),
    .tag_in  (iss_tag),
    .prod    (prod),
    .tag_out (mul_tag)
  );

  assign acc_sum = add_mod(mul_tag.first ? '0 : acc, prod);
  assign s_we    = mul_tag.valid && mul_tag.last;
  assign s_wa    = mk_addr(wi, wj);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows      <= ROWS_RESET;
      out_valid <= 1'b0;
      iss_tag   <= '0;
      cp_valid  <= 1'b0;
      sm_valid  <= 1'b0;
      wr_done   <= 1'b0;
    end else begin
      if (cfg_write) begin
        rows <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      iss_tag  <= '0;
      cp_valid <= 1'b0;
      sm_valid <= 1'b0;

      if (mul_tag.valid) begin
        acc <= acc_sum;
        if (mul_tag.last) begin
          if (wj == dim_m1) begin
            wj <= '0;
            if (wi == dim_m1) begin
              wr_done <= 1'b1;
            end else begin
              wi <= wi + 1'b1;
            end
          end else begin
            wj <= wj + 1'b1;
          end
        end
      end

      if (sm_valid) begin
        total <= add_mod(total, p_q);
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dim_m1 <= IDX_W'(dim_sat - 9'd1);
            expo   <= (column_count == '0) ? '0 : column_count - 1'b1;
            ci     <= '0;
            cj     <= '0;
            ck     <= '0;
            ntiles <= '0;
            state  <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (ck_last) begin
            ntiles <= '0;
            ck     <= '0;
            if (cj_last) begin
              cj <= '0;
              if (ci_last) begin
                state <= ST_PICK;
              end else begin
                ci <= ci + 1'b1;
              end
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ntiles <= bsum;
            ck     <= ck + 1'b1;
          end
        end
        ST_PICK: begin
          ci      <= '0;
          cj      <= '0;
          ck      <= '0;
          wi      <= '0;
          wj      <= '0;
          wr_done <= 1'b0;
          if (expo == '0) begin
            total <= '0;
            state <= ST_SUM;
          end else begin
            mul_to_p <= expo[0];
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          iss_tag <= '{valid: 1'b1, first: (ck == '0), last: ck_last};
          if (ck_last) begin
            ck <= '0;
            if (cj_last) begin
              cj <= '0;
              if (ci_last) begin
                ci    <= '0;
                state <= ST_DRAIN;
              end else begin
                ci <= ci + 1'b1;
              end
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ck <= ck + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (wr_done) begin
            ci    <= '0;
            cj    <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          cp_valid <= 1'b1;
          cp_addr  <= ij_addr;
          if (cj_last) begin
            cj <= '0;
            if (ci_last) begin
              state <= ST_COPY_END;
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        ST_COPY_END: begin
          if (mul_to_p) begin
            expo[0] <= 1'b0;
          end else begin
            expo <= expo >> 1;
          end
          state <= ST_PICK;
        end
        ST_SUM: begin
          sm_valid <= even_runs(RUN_W'(ci));
          if (cj_last) begin
            cj <= '0;
            if (ci_last) begin
              state <= ST_SUM_END;
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        ST_SUM_END: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            tiling_count <= total;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
